>>> hw/rtl/mrt_pkg.sv
// Package for the mapped region table: sizes, page constants, status codes,
// configuration register indexes and sequencer states.
// No dependencies.
`default_nettype none

package mrt_pkg;

    localparam int SLOTS  = 4;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

    localparam int ADDR_W = 38;
    localparam int LEN_W  = 27;
    localparam int REQ_W  = 32;
    localparam int CODE_W = 8;
    localparam int SUM_W  = ADDR_W + 1;
    localparam int CFG_W  = 3;

    localparam int SMALL_PAGE_BITS = 12;
    localparam int HUGE_PAGE_BITS  = SMALL_PAGE_BITS + 9;
    localparam int MAX_HUGE_PAGES  = 32;

    localparam logic [REQ_W-1:0] MAX_LEN =
        REQ_W'(MAX_HUGE_PAGES) << HUGE_PAGE_BITS;
    localparam logic [LEN_W-1:0] SMALL_MASK = LEN_W'((1 << SMALL_PAGE_BITS) - 1);
    localparam logic [LEN_W-1:0] HUGE_OFFS_MASK = LEN_W'((1 << HUGE_PAGE_BITS) - 1);

    localparam logic [ADDR_W-1:0] RST_WINDOW_LOW  = ADDR_W'(64'h0_8800_0000);
    localparam logic [ADDR_W-1:0] RST_WINDOW_HIGH = ADDR_W'(64'h3F_F000_0000);
    localparam logic [CODE_W-1:0] RST_PROT_READ   = CODE_W'(1);
    localparam logic [CODE_W-1:0] RST_PROT_WRITE  = CODE_W'(2);
    localparam logic [CODE_W-1:0] RST_PRIVATE     = CODE_W'(1);
    localparam logic [CODE_W-1:0] RST_SHARED      = CODE_W'(2);
    localparam logic [CODE_W-1:0] RST_HUGE        = CODE_W'(4);

    localparam logic CMD_MAP   = 1'b0;
    localparam logic CMD_UNMAP = 1'b1;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_ADDR  = 3'd1,
        ST_BAD_LEN   = 3'd2,
        ST_BAD_PROT  = 3'd3,
        ST_BAD_FLAGS = 3'd4,
        ST_OVERLAP   = 3'd5,
        ST_FULL      = 3'd6,
        ST_NOT_FOUND = 3'd7
    } t_status;

    typedef enum logic [CFG_W-1:0] {
        CFG_WINDOW_LOW  = 3'd0,
        CFG_WINDOW_HIGH = 3'd1,
        CFG_PROT_READ   = 3'd2,
        CFG_PROT_WRITE  = 3'd3,
        CFG_PRIVATE     = 3'd4,
        CFG_SHARED      = 3'd5,
        CFG_HUGE        = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_FINISH
    } t_state;

endpackage

`default_nettype wire

>>> hw/rtl/mapped_region_table.sv
// Mapped region table: validates map and unmap requests against a small slot table.
// Depends on mrt_pkg.
// Sequence: accept in idle, then check, a scan of the slots (skipped when check refuses
// the request), and finish, which waits until the output register is free. The single
// shared adder and the comparators walk the slots one at a time (two passes per occupied
// slot on map); input stays stalled until finish has loaded the output and returned to idle.
// Synchronous reset empties every slot and loads the default configuration.
`default_nettype none

module mapped_region_table
    import mrt_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,

    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_W-1:0]        i_cfg_addr,
    input  wire logic [ADDR_W-1:0]       i_cfg_data,

    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire logic                    i_cmd,
    input  wire logic [ADDR_W-1:0]       i_start_addr,
    input  wire logic signed [REQ_W-1:0] i_req_length,
    input  wire logic [CODE_W-1:0]       i_prot_value,
    input  wire logic [CODE_W-1:0]       i_flag_value,

    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    output logic [2:0]                   o_status,
    output logic [ADDR_W-1:0]            o_out_addr,
    output logic [LEN_W-1:0]             o_out_length,
    output logic                         o_out_huge
);

    logic [ADDR_W-1:0] r_window_low, r_window_high;
    logic [CODE_W-1:0] r_prot_read, r_prot_write, r_private, r_shared, r_huge_code;

    logic [ADDR_W-1:0] r_slot_start [SLOTS];
    logic [LEN_W-1:0]  r_slot_length [SLOTS];
    logic [CODE_W-1:0] r_slot_attr [SLOTS];

    t_state            r_state, n_state;
    logic              r_cmd;
    logic [ADDR_W-1:0] r_addr;
    logic [REQ_W-1:0]  r_lraw;
    logic [CODE_W-1:0] r_prot, r_flg;
    logic [LEN_W-1:0]  r_len, n_len;
    logic              r_huge, n_huge;
    logic [SLOT_W-1:0] r_idx, n_idx;
    logic              r_phase, n_phase;
    logic              r_free_found, n_free_found;
    logic [SLOT_W-1:0] r_tgt, n_tgt;
    t_status           r_res, n_res;

    logic              r_o_valid;
    t_status           r_o_status;
    logic [ADDR_W-1:0] r_o_addr;
    logic [LEN_W-1:0]  r_o_len;
    logic              r_o_huge;

    logic [SUM_W-1:0]  add_a, add_b, add_sum;
    logic [ADDR_W-1:0] cur_start;
    logic [LEN_W-1:0]  cur_len;
    logic [SUM_W-1:0]  a_ext, s_ext;
    logic              addr_bad, len_bad, prot_bad, flg_bad, flg_huge;
    logic              out_free, load_out, in_acc;
    logic              slot_we;
    logic [ADDR_W-1:0] slot_wr_start;
    logic [LEN_W-1:0]  slot_wr_len;
    logic [CODE_W-1:0] slot_wr_attr;
    logic [LEN_W-1:0]  ld_len;
    logic              ld_huge;
    logic [ADDR_W-1:0] ld_addr;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_o_valid || !i_out_stall;

    assign cur_start = r_slot_start[r_idx];
    assign cur_len   = r_slot_length[r_idx];
    assign a_ext     = {1'b0, r_addr};
    assign s_ext     = {1'b0, cur_start};

    assign addr_bad = (r_addr < r_window_low) || (r_addr > r_window_high) ||
                      (r_addr[SMALL_PAGE_BITS-1:0] != '0);
    assign len_bad  = r_lraw[REQ_W-1] || (r_lraw == '0) || (r_lraw > MAX_LEN);
    assign prot_bad = (r_prot != r_prot_read) && (r_prot != r_prot_write);
    assign flg_bad  = !((r_flg == r_private) || (r_flg == r_shared) ||
                        (r_flg == (r_private | r_huge_code)) ||
                        (r_flg == (r_shared | r_huge_code)));
    assign flg_huge = (r_flg != r_private) && (r_flg != r_shared);

    // shared adder: page rounding in check, region end in scan
    always_comb begin
        add_a = a_ext;
        add_b = SUM_W'(r_len);
        if (r_state == S_CHECK) begin
            add_a = SUM_W'(r_lraw[LEN_W-1:0]);
            add_b = flg_huge ? SUM_W'(HUGE_OFFS_MASK) : SUM_W'(SMALL_MASK);
        end else if (!r_phase) begin
            add_a = s_ext;
            add_b = SUM_W'(cur_len);
        end
    end
    assign add_sum = add_a + add_b;

    always_comb begin
        n_state      = r_state;
        n_len        = r_len;
        n_huge       = r_huge;
        n_idx        = r_idx;
        n_phase      = r_phase;
        n_free_found = r_free_found;
        n_tgt        = r_tgt;
        n_res        = r_res;
        load_out     = 1'b0;
        slot_we      = 1'b0;
        slot_wr_start = r_addr;
        slot_wr_len   = r_len;
        slot_wr_attr  = r_prot | r_flg;
        ld_addr      = '0;
        ld_len       = '0;
        ld_huge      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_idx        = '0;
                n_phase      = 1'b0;
                n_free_found = 1'b0;
                n_huge       = flg_huge;
                n_len        = add_sum[LEN_W-1:0] &
                               ~(flg_huge ? HUGE_OFFS_MASK : SMALL_MASK);
                n_state      = S_FINISH;
                if (addr_bad) begin
                    n_res = ST_BAD_ADDR;
                end else if (r_cmd == CMD_UNMAP) begin
                    n_state = S_SCAN;
                end else if (len_bad) begin
                    n_res = ST_BAD_LEN;
                end else if (prot_bad) begin
                    n_res = ST_BAD_PROT;
                end else if (flg_bad) begin
                    n_res = ST_BAD_FLAGS;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_cmd == CMD_UNMAP) begin
                    if (cur_start != '0 && cur_start == r_addr) begin
                        n_res   = ST_OK;
                        n_tgt   = r_idx;
                        n_state = S_FINISH;
                    end else if (r_idx == LAST_SLOT) begin
                        n_res   = ST_NOT_FOUND;
                        n_state = S_FINISH;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end else begin
                    if (cur_start == '0 && !r_free_found) begin
                        n_free_found = 1'b1;
                        n_tgt        = r_idx;
                    end
                    if (cur_start != '0 && !r_phase &&
                        s_ext <= a_ext && a_ext < add_sum) begin
                        n_res   = ST_OVERLAP;
                        n_state = S_FINISH;
                    end else if (cur_start != '0 && r_phase &&
                                 a_ext <= s_ext && s_ext < add_sum) begin
                        n_res   = ST_OVERLAP;
                        n_state = S_FINISH;
                    end else if (cur_start != '0 && !r_phase) begin
                        n_phase = 1'b1;
                    end else begin
                        n_phase = 1'b0;
                        if (r_idx == LAST_SLOT) begin
                            n_res   = n_free_found ? ST_OK : ST_FULL;
                            n_state = S_FINISH;
                        end else begin
                            n_idx = r_idx + 1'b1;
                        end
                    end
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                    if (r_res == ST_OK) begin
                        slot_we = 1'b1;
                        ld_addr = r_addr;
                        if (r_cmd == CMD_UNMAP) begin
                            slot_wr_start = '0;
                            slot_wr_len   = '0;
                            slot_wr_attr  = '0;
                            ld_len  = r_slot_length[r_tgt];
                            ld_huge = (r_slot_attr[r_tgt] & r_huge_code) != '0;
                        end else begin
                            ld_len  = r_len;
                            ld_huge = r_huge;
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_o_valid     <= 1'b0;
            r_window_low  <= RST_WINDOW_LOW;
            r_window_high <= RST_WINDOW_HIGH;
            r_prot_read   <= RST_PROT_READ;
            r_prot_write  <= RST_PROT_WRITE;
            r_private     <= RST_PRIVATE;
            r_shared      <= RST_SHARED;
            r_huge_code   <= RST_HUGE;
            for (int i = 0; i < SLOTS; i++) begin
                r_slot_start[i]  <= '0;
                r_slot_length[i] <= '0;
                r_slot_attr[i]   <= '0;
            end
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_WINDOW_LOW:  r_window_low  <= i_cfg_data;
                    CFG_WINDOW_HIGH: r_window_high <= i_cfg_data;
                    CFG_PROT_READ:   r_prot_read   <= i_cfg_data[CODE_W-1:0];
                    CFG_PROT_WRITE:  r_prot_write  <= i_cfg_data[CODE_W-1:0];
                    CFG_PRIVATE:     r_private     <= i_cfg_data[CODE_W-1:0];
                    CFG_SHARED:      r_shared      <= i_cfg_data[CODE_W-1:0];
                    CFG_HUGE:        r_huge_code   <= i_cfg_data[CODE_W-1:0];
                    default: ;
                endcase
            end
            if (slot_we) begin
                r_slot_start[r_tgt]  <= slot_wr_start;
                r_slot_length[r_tgt] <= slot_wr_len;
                r_slot_attr[r_tgt]   <= slot_wr_attr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_len        <= n_len;
        r_huge       <= n_huge;
        r_idx        <= n_idx;
        r_phase      <= n_phase;
        r_free_found <= n_free_found;
        r_tgt        <= n_tgt;
        r_res        <= n_res;
        if (in_acc) begin
            r_cmd  <= i_cmd;
            r_addr <= i_start_addr;
            r_lraw <= i_req_length;
            r_prot <= i_prot_value;
            r_flg  <= i_flag_value;
        end
        if (load_out) begin
            r_o_status <= r_res;
            r_o_addr   <= ld_addr;
            r_o_len    <= ld_len;
            r_o_huge   <= ld_huge;
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_o_valid;
    assign o_status     = r_o_status;
    assign o_out_addr   = r_o_addr;
    assign o_out_length = r_o_len;
    assign o_out_huge   = r_o_huge;

    a_accept_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_CHECK))
        else $error("accepted word did not enter check");

    a_load_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_FINISH))
        else $error("result loaded outside finish");

    a_ok_has_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_OK) |-> (o_out_length != '0))
        else $error("successful result with zero length");

    a_err_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |->
            (o_out_addr == '0 && o_out_length == '0 && !o_out_huge))
        else $error("refused result carries payload");

endmodule

`default_nettype wire
